### rtl/assert_macros.svh
// Assertion macros included by the top-level RTL file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed: label");

// Check a property on every rising clock edge, reset included
`define ASSERT_ALWAYS(label, clk, prop) \
	label: assert property (@(posedge clk) (prop)) \
		else $error("assertion failed: label");

`endif

### rtl/iost_pkg.sv
// Types and constants of the interval overlap sweep table
`default_nettype none
package iost_pkg;
	localparam int unsigned TABLE_DEPTH = 256;
	localparam int unsigned AW = $clog2(TABLE_DEPTH);

	localparam logic [1:0] MODE_PUSH    = 2'd0;
	localparam logic [1:0] MODE_UPDATE  = 2'd1;
	localparam logic [1:0] MODE_CLEANUP = 2'd2;
	localparam logic [1:0] MODE_QUERY   = 2'd3;

	localparam logic [1:0] ST_DONE = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_ZERO = 2'd2;

	typedef struct packed {
		logic [1:0]  mode;
		logic [31:0] position;
		logic [31:0] length;
		logic [15:0] count;
		logic [8:0]  from_index;
		logic [8:0]  to_index;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] peak_count;
		logic [8:0]  found_index;
	} out_item_t;

	typedef struct packed {
		logic [31:0]        pos;
		logic signed [16:0] delta;
		logic [15:0]        sum;
	} entry_t;

	typedef struct packed {
		logic          wen;
		logic [AW-1:0] waddr;
		entry_t        wdata;
		logic [AW-1:0] raddr;
	} mem_ctl_t;
endpackage
`default_nettype wire

### rtl/iost_mem.sv
// Entry table memory with one write and one registered read port
`default_nettype none
module iost_mem import iost_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire mem_ctl_t ctl,
	output entry_t        rdata
);
	entry_t mem [TABLE_DEPTH];
	entry_t rdata_q;
	logic   front_wr_q;
	logic   rd_front_q;

	always_ff @(posedge clk) begin
		if (ctl.wen) begin
			mem[ctl.waddr] <= ctl.wdata;
		end
		rdata_q <= mem[ctl.raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_wr_q <= 1'b0;
			rd_front_q <= 1'b0;
		end else begin
			rd_front_q <= (ctl.raddr == '0);
			if (ctl.wen && ctl.waddr == '0) begin
				front_wr_q <= 1'b1;
			end
		end
	end

	assign rdata = (rd_front_q && !front_wr_q) ? entry_t'('0) : rdata_q;
endmodule
`default_nettype wire

### rtl/interval_overlap_sweep_table_top.sv
// Top level: sequencer of the interval overlap sweep table
//
//  channel | direction | handshake           | payload
//  in      | input     | in_valid / in_ready | in_item  (mode, position, ...)
//  out     | output    | out_valid/out_ready | out_item (status, peak_count, index)
//
// One item at a time; each walks the table through the single memory read port,
// with a read state and then a compare or write state for each entry visited.
// Reset leaves one zero entry; no clearing pass is needed.
// in_ready is high only while idle; a result holds until out_ready.
`default_nettype none
`include "assert_macros.svh"
module interval_overlap_sweep_table_top import iost_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire in_item_t  in_item,
	output logic           out_valid,
	input  wire logic      out_ready,
	output out_item_t      out_item
);
	typedef enum logic [4:0] {
		IDLE, P_RD, P_CMP, P_WR, U_RD, U_CMP, S_RD0, S_LD, S_RD, S_CMP,
		C_RD, C_CMP, C_END, C_SRD, C_SWR, Q_LD, Q_RD, Q_CMP, RESP
	} state_t;

	state_t             state_q;
	logic [8:0]         used_q, i_q, wr_q, to_q, lo_q;
	logic               phase_q;
	logic [31:0]        key_q, end_q;
	logic signed [16:0] ins_delta_q;
	logic [15:0]        cnt_q, cur_q, best_q;
	entry_t             last_q;
	out_item_t          res_q;

	mem_ctl_t           ctl;
	entry_t             rdata;

	logic [32:0]        end_sum;
	logic [31:0]        end_sat;
	logic [8:0]         to_c, from_c;
	logic signed [17:0] merge_sum;
	logic signed [16:0] merge_sat;
	logic signed [18:0] run_sum;
	logic [15:0]        run_sat;
	logic [8:0]         i_dec;

	iost_mem u_mem (.clk(clk), .arst_n(arst_n), .ctl(ctl), .rdata(rdata));

	assign end_sum = {1'b0, in_item.position} + {1'b0, in_item.length};
	assign end_sat = end_sum[32] ? '1 : end_sum[31:0];
	assign to_c    = (in_item.to_index > used_q) ? used_q : in_item.to_index;
	assign from_c  = (in_item.from_index > to_c) ? to_c : in_item.from_index;
	assign i_dec   = i_q - 9'd1;

	assign merge_sum = 18'(last_q.delta) + 18'(rdata.delta);
	assign merge_sat = (merge_sum > 18'sd65535) ? 17'sd65535 :
		(merge_sum < -18'sd65536) ? -17'sd65536 : merge_sum[16:0];
	assign run_sum = $signed({3'b000, cur_q}) + 19'(rdata.delta);
	assign run_sat = (run_sum > 19'sd65535) ? 16'hFFFF :
		(run_sum < 19'sd0) ? 16'h0000 : run_sum[15:0];

	always_comb begin
		ctl = '0;
		case (state_q)
			IDLE: begin
				ctl.raddr = (in_item.mode == MODE_QUERY) ? AW'(from_c - 9'd1) : '0;
			end
			P_RD: ctl.raddr = i_dec[AW-1:0];
			P_CMP: begin
				ctl.wen   = rdata.pos > key_q;
				ctl.waddr = i_q[AW-1:0];
				ctl.wdata = rdata;
			end
			P_WR: begin
				ctl.wen   = 1'b1;
				ctl.waddr = i_q[AW-1:0];
				ctl.wdata = '{pos: key_q, delta: ins_delta_q, sum: 16'h0000};
			end
			U_RD, S_RD, C_RD, C_SRD, Q_RD: ctl.raddr = i_q[AW-1:0];
			U_CMP: begin
				ctl.wen = 1'b1;
				if (wr_q > 9'd1 && last_q.pos == rdata.pos) begin
					ctl.waddr = AW'(wr_q - 9'd1);
					ctl.wdata = '{pos: last_q.pos, delta: merge_sat, sum: last_q.sum};
				end else begin
					ctl.waddr = wr_q[AW-1:0];
					ctl.wdata = rdata;
				end
			end
			S_CMP: begin
				ctl.wen   = 1'b1;
				ctl.waddr = i_q[AW-1:0];
				ctl.wdata = '{pos: rdata.pos, delta: rdata.delta, sum: run_sat};
			end
			C_SWR: begin
				ctl.wen   = 1'b1;
				ctl.waddr = AW'(i_q - wr_q);
				ctl.wdata = rdata;
			end
			default: ctl.raddr = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			used_q  <= 9'd1;
		end else begin
			case (state_q)
				IDLE: if (in_valid) begin
					cnt_q <= in_item.count;
					case (in_item.mode)
						MODE_PUSH: begin
							if (in_item.count == '0) begin
								res_q   <= '{status: ST_ZERO, peak_count: '0, found_index: '0};
								state_q <= RESP;
							end else if ({1'b0, used_q} + 10'd2 > 10'(TABLE_DEPTH)) begin
								res_q   <= '{status: ST_FULL, peak_count: '0, found_index: '0};
								state_q <= RESP;
							end else begin
								res_q       <= '0;
								key_q       <= in_item.position;
								end_q       <= end_sat;
								ins_delta_q <= $signed({1'b0, in_item.count});
								phase_q     <= 1'b0;
								i_q         <= used_q;
								state_q     <= P_RD;
							end
						end
						MODE_UPDATE: begin
							res_q   <= '0;
							i_q     <= 9'd1;
							wr_q    <= 9'd1;
							state_q <= U_RD;
						end
						MODE_CLEANUP: begin
							res_q   <= '0;
							key_q   <= in_item.position;
							i_q     <= '0;
							state_q <= C_RD;
						end
						default: begin
							res_q   <= '0;
							key_q   <= in_item.position;
							end_q   <= end_sat;
							to_q    <= to_c;
							i_q     <= from_c;
							lo_q    <= from_c;
							best_q  <= '0;
							phase_q <= 1'b0;
							state_q <= (from_c != '0) ? Q_LD : Q_RD;
						end
					endcase
				end
				P_RD: state_q <= P_CMP;
				P_CMP: begin
					if (rdata.pos > key_q) begin
						i_q     <= i_dec;
						state_q <= (i_q == 9'd1) ? P_WR : P_RD;
					end else begin
						state_q <= P_WR;
					end
				end
				P_WR: begin
					used_q <= used_q + 9'd1;
					if (!phase_q) begin
						phase_q     <= 1'b1;
						key_q       <= end_q;
						ins_delta_q <= -$signed({1'b0, cnt_q});
						i_q         <= used_q + 9'd1;
						state_q     <= P_RD;
					end else begin
						state_q <= RESP;
					end
				end
				U_RD: state_q <= (i_q >= used_q) ? S_RD0 : U_CMP;
				U_CMP: begin
					if (wr_q > 9'd1 && last_q.pos == rdata.pos) begin
						last_q.delta <= merge_sat;
					end else begin
						last_q <= rdata;
						wr_q   <= wr_q + 9'd1;
					end
					i_q     <= i_q + 9'd1;
					state_q <= U_RD;
				end
				S_RD0: begin
					used_q  <= wr_q;
					state_q <= S_LD;
				end
				S_LD: begin
					cur_q   <= rdata.sum;
					i_q     <= 9'd1;
					state_q <= S_RD;
				end
				S_RD: state_q <= (i_q >= used_q) ? RESP : S_CMP;
				S_CMP: begin
					cur_q   <= run_sat;
					i_q     <= i_q + 9'd1;
					state_q <= S_RD;
				end
				C_RD: state_q <= (i_q >= used_q) ? C_END : C_CMP;
				C_CMP: begin
					if (rdata.pos < key_q) begin
						i_q     <= i_q + 9'd1;
						state_q <= C_RD;
					end else begin
						state_q <= C_END;
					end
				end
				C_END: begin
					if (i_q <= 9'd1) begin
						state_q <= RESP;
					end else begin
						wr_q    <= i_dec;
						i_q     <= i_dec;
						state_q <= C_SRD;
					end
				end
				C_SRD: begin
					if (i_q >= used_q) begin
						used_q  <= used_q - wr_q;
						state_q <= RESP;
					end else begin
						state_q <= C_SWR;
					end
				end
				C_SWR: begin
					i_q     <= i_q + 9'd1;
					state_q <= C_SRD;
				end
				Q_LD: begin
					best_q  <= rdata.sum;
					state_q <= Q_RD;
				end
				Q_RD: begin
					if (i_q >= to_q) begin
						res_q   <= '{status: ST_DONE, peak_count: best_q, found_index: lo_q};
						state_q <= RESP;
					end else begin
						state_q <= Q_CMP;
					end
				end
				Q_CMP: begin
					if (!phase_q && rdata.pos < key_q) begin
						i_q     <= i_q + 9'd1;
						lo_q    <= i_q + 9'd1;
						state_q <= Q_RD;
					end else if (rdata.pos < end_q) begin
						phase_q <= 1'b1;
						if (rdata.sum > best_q) begin
							best_q <= rdata.sum;
						end
						i_q     <= i_q + 9'd1;
						state_q <= Q_RD;
					end else begin
						res_q   <= '{status: ST_DONE, peak_count: best_q, found_index: lo_q};
						state_q <= RESP;
					end
				end
				RESP: if (out_ready) begin
					state_q <= IDLE;
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	assign in_ready  = (state_q == IDLE);
	assign out_valid = (state_q == RESP);
	assign out_item  = res_q;

	`ASSERT_CLK(a_used_range, clk, arst_n, used_q >= 9'd1 && used_q <= 9'(TABLE_DEPTH))
	`ASSERT_CLK(a_one_side, clk, arst_n, !(in_ready && out_valid))
	`ASSERT_CLK(a_resp_hold, clk, arst_n, out_valid && !out_ready |=> out_valid && $stable(out_item))
endmodule
`default_nettype wire

### test/tb_interval_overlap_sweep_table_top.sv
// Testbench of the interval overlap sweep table: directed table, then random items
`timescale 1ns / 100ps
`default_nettype none
module tb_interval_overlap_sweep_table_top;
	import iost_pkg::*;

	localparam int DEPTH = 256;
	localparam int WATCHDOG = 200000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_item_t in_item = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_item_t out_item;

	always #1 clk = ~clk;

	interval_overlap_sweep_table_top u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
		.out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
	);

	// shadow table
	logic [31:0] tab_pos [DEPTH];
	int tab_delta [DEPTH];
	int tab_sum [DEPTH];
	int tab_used;

	out_item_t expected_q[$];
	int fails = 0;
	int idle_cycles = 0;
	int rx_gap = 0;
	bit quiet = 1'b0;
	bit hold_rx = 1'b0;

	function automatic logic [31:0] sat_end(logic [31:0] p, logic [31:0] l);
		logic [32:0] e;
		e = {1'b0, p} + {1'b0, l};
		return e[32] ? 32'hFFFF_FFFF : e[31:0];
	endfunction

	function automatic void table_insert(logic [31:0] p, int d);
		int i;
		i = tab_used;
		while (i > 0 && tab_pos[i-1] > p) begin
			tab_pos[i] = tab_pos[i-1];
			tab_delta[i] = tab_delta[i-1];
			tab_sum[i] = tab_sum[i-1];
			i--;
		end
		tab_pos[i] = p;
		tab_delta[i] = d;
		tab_sum[i] = 0;
		tab_used++;
	endfunction

	function automatic out_item_t sweep_step(in_item_t it);
		out_item_t r;
		int wr, cur, s, p, drop, to, from, lo, hi, best;
		logic [31:0] e;
		r = '0;
		case (it.mode)
		MODE_PUSH: begin
			if (it.count == 0) begin
				r.status = ST_ZERO;
			end else if (tab_used + 2 > DEPTH) begin
				r.status = ST_FULL;
			end else begin
				table_insert(it.position, int'(it.count));
				table_insert(sat_end(it.position, it.length), -int'(it.count));
				r.status = ST_DONE;
			end
		end
		MODE_UPDATE: begin
			wr = 1;
			for (int rd = 1; rd < tab_used; rd++) begin
				if (wr > 1 && tab_pos[wr-1] == tab_pos[rd]) begin
					s = tab_delta[wr-1] + tab_delta[rd];
					if (s > 65535) s = 65535;
					if (s < -65536) s = -65536;
					tab_delta[wr-1] = s;
				end else begin
					tab_pos[wr] = tab_pos[rd];
					tab_delta[wr] = tab_delta[rd];
					tab_sum[wr] = tab_sum[rd];
					wr++;
				end
			end
			tab_used = wr;
			cur = tab_sum[0];
			for (int rd = 1; rd < tab_used; rd++) begin
				cur += tab_delta[rd];
				if (cur > 65535) cur = 65535;
				if (cur < 0) cur = 0;
				tab_sum[rd] = cur;
			end
		end
		MODE_CLEANUP: begin
			p = 0;
			while (p < tab_used && tab_pos[p] < it.position) p++;
			if (p > 1) begin
				drop = p - 1;
				for (int i = drop; i < tab_used; i++) begin
					tab_pos[i-drop] = tab_pos[i];
					tab_delta[i-drop] = tab_delta[i];
					tab_sum[i-drop] = tab_sum[i];
				end
				tab_used -= drop;
			end
		end
		default: begin
			e = sat_end(it.position, it.length);
			to = it.to_index;
			from = it.from_index;
			best = 0;
			if (to > tab_used) to = tab_used;
			if (from > to) from = to;
			lo = from;
			while (lo < to && tab_pos[lo] < it.position) lo++;
			hi = lo;
			while (hi < to && tab_pos[hi] < e) hi++;
			if (lo != to && lo != hi)
				for (int i = lo; i < hi; i++)
					if (tab_sum[i] > best) best = tab_sum[i];
			if (from > 0 && tab_sum[from-1] > best) best = tab_sum[from-1];
			r.peak_count = best[15:0];
			r.found_index = lo[8:0];
		end
		endcase
		return r;
	endfunction

	function automatic in_item_t make_item(logic [1:0] m, logic [31:0] p, logic [31:0] l,
			logic [15:0] c, logic [8:0] f, logic [8:0] t);
		in_item_t it;
		it.mode = m;
		it.position = p;
		it.length = l;
		it.count = c;
		it.from_index = f;
		it.to_index = t;
		return it;
	endfunction

	task automatic send_item(in_item_t it);
		int gap;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 15);
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_item <= it;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		expected_q.push_back(sweep_step(it));
		@(negedge clk);
	endtask

	// check results
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected item %p", $time, out_item);
				fails++;
			end else begin
				want = expected_q.pop_front();
				if (out_item.status !== want.status)
					$display("%0t: status expected %0d actual %0d", $time, want.status,
						out_item.status);
				if (out_item.peak_count !== want.peak_count)
					$display("%0t: peak_count expected %0d actual %0d", $time,
						want.peak_count, out_item.peak_count);
				if (out_item.found_index !== want.found_index)
					$display("%0t: found_index expected %0d actual %0d", $time,
						want.found_index, out_item.found_index);
				if (out_item !== want) fails++;
			end
		end
	end

	// receiver idling
	always @(negedge clk) begin
		if (hold_rx) begin
			out_ready <= 1'b0;
		end else if (quiet) begin
			out_ready <= 1'b1;
		end else if (rx_gap > 0) begin
			out_ready <= 1'b0;
			rx_gap <= rx_gap - 1;
		end else if ($urandom_range(0, 3) == 0) begin
			out_ready <= 1'b0;
			rx_gap <= $urandom_range(0, 14);
		end else begin
			out_ready <= 1'b1;
		end
	end

	// long hold-off while the sender keeps offering
	initial begin
		wait (arst_n);
		repeat (300) @(negedge clk);
		hold_rx = 1'b1;
		repeat (3000) @(negedge clk);
		hold_rx = 1'b0;
	end

	// watchdog
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG) begin
			$display("tb_interval_overlap_sweep_table_top failed");
			$finish;
		end
	end

	typedef struct {
		in_item_t it;
		bit typed;
		out_item_t want;
	} stim_row_t;

	stim_row_t directed[$];

	task automatic add_row(in_item_t it, bit typed, out_item_t want);
		stim_row_t r;
		r.it = it;
		r.typed = typed;
		r.want = want;
		directed.push_back(r);
	endtask

	function automatic out_item_t res(logic [1:0] s, logic [15:0] m, logic [8:0] f);
		out_item_t r;
		r.status = s;
		r.peak_count = m;
		r.found_index = f;
		return r;
	endfunction

	function automatic in_item_t rand_item(int n);
		in_item_t it;
		int k;
		logic [31:0] base;
		it = make_item(2'($urandom_range(0, 3)), $urandom, $urandom, 16'($urandom),
			9'($urandom), 9'($urandom));
		k = $urandom_range(0, 9);
		base = $urandom_range(0, 2000);
		if (k < 5) begin
			it.mode = MODE_PUSH;
			it.position = (k == 0) ? $urandom : base;
			it.length = (k == 1) ? $urandom : $urandom_range(0, 300);
			it.count = (k == 2) ? 16'($urandom) :
				((n % 40 == 0) ? 16'd0 : 16'($urandom_range(1, 9)));
		end else if (k < 7) begin
			it.mode = MODE_UPDATE;
		end else if (k == 7) begin
			it.mode = MODE_CLEANUP;
			it.position = ($urandom_range(0, 5) == 0) ? $urandom : base / 4;
		end else begin
			it.mode = MODE_QUERY;
			it.position = ($urandom_range(0, 5) == 0) ? $urandom : base;
			it.length = ($urandom_range(0, 5) == 0) ? $urandom : $urandom_range(0, 500);
			it.from_index = 9'($urandom_range(0, 300));
			it.to_index = 9'($urandom_range(0, 300));
		end
		return it;
	endfunction

	initial begin
		int n;
		tab_used = 1;
		for (int i = 0; i < DEPTH; i++) begin
			tab_pos[i] = '0;
			tab_delta[i] = 0;
			tab_sum[i] = 0;
		end
		add_row(make_item(MODE_QUERY, 0, 0, 0, 0, 256), 1, res(ST_DONE, 0, 0));
		add_row(make_item(MODE_PUSH, 10, 5, 0, 0, 0), 1, res(ST_ZERO, 0, 0));
		add_row(make_item(MODE_PUSH, 100, 50, 16'hFFFF, 0, 0), 1, res(ST_DONE, 0, 0));
		add_row(make_item(MODE_PUSH, 100, 50, 16'hFFFF, 0, 0), 0, '0);
		add_row(make_item(MODE_PUSH, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 3, 0, 0), 0, '0);
		add_row(make_item(MODE_PUSH, 120, 0, 7, 0, 0), 0, '0);
		add_row(make_item(MODE_PUSH, 130, 10, 1, 0, 0), 0, '0);
		add_row(make_item(MODE_UPDATE, 0, 0, 0, 0, 0), 1, res(ST_DONE, 0, 0));
		add_row(make_item(MODE_QUERY, 0, 32'hFFFF_FFFF, 0, 0, 511), 0, '0);
		add_row(make_item(MODE_QUERY, 100, 1, 0, 3, 1), 0, '0);
		add_row(make_item(MODE_QUERY, 125, 20, 0, 2, 6), 0, '0);
		add_row(make_item(MODE_QUERY, 32'hFFFF_FFFF, 0, 0, 0, 0), 0, '0);
		add_row(make_item(MODE_PUSH, 0, 0, 2, 0, 0), 0, '0);
		add_row(make_item(MODE_UPDATE, 0, 0, 0, 0, 0), 0, '0);
		add_row(make_item(MODE_CLEANUP, 0, 0, 0, 0, 0), 1, res(ST_DONE, 0, 0));
		add_row(make_item(MODE_CLEANUP, 125, 0, 0, 0, 0), 0, '0);
		add_row(make_item(MODE_QUERY, 0, 200, 0, 1, 256), 0, '0);
		add_row(make_item(MODE_CLEANUP, 32'hFFFF_FFFF, 0, 0, 0, 0), 0, '0);
		add_row(make_item(MODE_QUERY, 0, 32'hFFFF_FFFF, 0, 0, 9), 0, '0);
		add_row(make_item(MODE_UPDATE, 0, 0, 0, 0, 0), 0, '0);

		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed[i]) begin
			send_item(directed[i].it);
			if (directed[i].typed && expected_q[$] !== directed[i].want) begin
				$display("%0t: row %0d expected %p actual %p", $time, i,
					directed[i].want, expected_q[$]);
				fails++;
			end
		end

		// fill the table to hit the full flag, then random items
		for (n = 0; n < 140; n++)
			send_item(make_item(MODE_PUSH, $urandom_range(0, 5000), $urandom_range(0, 400),
				16'($urandom_range(1, 16'hFFFF)), 0, 0));
		send_item(make_item(MODE_UPDATE, 0, 0, 0, 0, 0));
		send_item(make_item(MODE_QUERY, 0, 32'hFFFF_FFFF, 0, 0, 256));
		send_item(make_item(MODE_CLEANUP, 4000, 0, 0, 0, 0));
		for (n = 0; n < 440; n++) begin
			if (n == 380) quiet = 1'b1;
			send_item(rand_item(n));
		end
		in_valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (2200) @(posedge clk);
		if (fails == 0 && expected_q.size() == 0) begin
			$display("tb_interval_overlap_sweep_table_top passed");
		end else begin
			$display("tb_interval_overlap_sweep_table_top failed");
		end
		$finish;
	end
endmodule
`default_nettype wire
